>>> design/elc_pkg.sv
package elc_pkg;

    localparam int MAX_FLOORS = 64;
    localparam int COUNT_BITS = 8;
    localparam int FLOOR_W    = $clog2(MAX_FLOORS);
    localparam int NF_W       = 7;
    localparam int CAP_W      = 8;
    localparam int TOTAL_W    = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [NF_W-1:0]       FLOORS_RESET = NF_W'(50);
    localparam logic [CAP_W-1:0]      CAP_RESET    = CAP_W'(255);
    localparam logic [COUNT_BITS-1:0] CNT_MAX      = {COUNT_BITS{1'b1}};

    typedef logic [FLOOR_W-1:0]    t_floor;
    typedef logic [COUNT_BITS-1:0] t_count;

    typedef enum logic [1:0] {
        CMD_PRESS  = 2'd0,
        CMD_BOARD  = 2'd1,
        CMD_ALIGHT = 2'd2,
        CMD_TICK   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLOORS   = 1'b0,
        CFG_CAPACITY = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        t_cmd   cmd;
        t_floor floor;
        t_floor target;
    } t_in_item;

    typedef struct packed {
        logic               accepted;
        t_floor             car_floor;
        logic               going_up;
        logic [CAP_W-1:0]   riders;
        logic               exits_waiting;
        logic               entries_waiting;
        logic [TOTAL_W-1:0] transported_total;
    } t_out_item;

    // write request into one per-floor counter store
    typedef struct packed {
        logic   en;
        t_floor addr;
        t_count val;
    } t_cnt_wr;

endpackage

>>> design/elc_ram.sv
module elc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

>>> design/elc_cnt_store.sv
module elc_cnt_store (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  elc_pkg::t_floor                i_rd_addr,
    output elc_pkg::t_count                o_rd_val,
    input  elc_pkg::t_cnt_wr               i_wr,
    output logic [elc_pkg::MAX_FLOORS-1:0] o_nz
);

    import elc_pkg::*;

    t_count                w_q;
    t_floor                r_rd_addr;
    t_cnt_wr               r_byp;
    logic [MAX_FLOORS-1:0] r_nz;

    elc_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (MAX_FLOORS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_wr.en),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.val),
        .i_raddr (i_rd_addr),
        .o_rdata (w_q)
    );

    always_ff @(posedge i_clk) begin
        r_rd_addr  <= i_rd_addr;
        r_byp.addr <= i_wr.addr;
        r_byp.val  <= i_wr.val;
        if (!i_rst_n) begin
            r_byp.en <= 1'b0;
            r_nz     <= '0;
        end else begin
            r_byp.en <= i_wr.en;
            if (i_wr.en) begin
                r_nz[i_wr.addr] <= (i_wr.val != '0);
            end
        end
    end

    // last cycle's write is not yet visible at the RAM read port: forward it.
    // A clear flag means zero, so entries never written since reset read as zero.
    always_comb begin
        if (r_byp.en && (r_byp.addr == r_rd_addr)) begin
            o_rd_val = r_byp.val;
        end else if (r_nz[r_rd_addr]) begin
            o_rd_val = w_q;
        end else begin
            o_rd_val = '0;
        end
    end

    assign o_nz = r_nz;

    a_nz_tracks_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.en |=> (r_nz[$past(i_wr.addr)] == ($past(i_wr.val) != '0)))
        else $error("nonzero flag does not follow written count");

endmodule

>>> design/elevator_look_controller_top.sv
// LOOK scheduler for one elevator car. Events (press, board, alight, tick) are taken
// on any clock where start is high; busy never rises, so one event per clock is
// sustained. Each event yields exactly one result, strobed on o_strobe for a single
// cycle: the transfer edge registers the event and starts the per-floor counter
// memory reads, then the result is registered and strobed. The receiver cannot
// stall the result. Throughput is set by the read-modify-write of the three
// per-floor counter RAMs, closed by a one-entry write bypass; direction choice is
// an OR over per-floor nonzero flags held in flops. Reset clears all counters at
// once through those flags, so no clearing pass is needed. Configuration writes
// take effect on the next clock and should be done only while no event is in flight.
module elevator_look_controller_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  elc_pkg::t_in_item              i_item,
    output logic                           o_strobe,
    output elc_pkg::t_out_item             o_result,
    input  logic                           i_cfg_we,
    input  elc_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [elc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import elc_pkg::*;

    logic               r_vld;
    t_in_item           r_item;
    logic [NF_W-1:0]    r_floors;
    logic [CAP_W-1:0]   r_cap;
    t_floor             r_cf;
    logic               r_dir;
    logic [CAP_W-1:0]   r_rc;
    logic [TOTAL_W-1:0] r_deliv;
    logic               r_strobe;
    t_out_item          r_result;

    t_floor             n_cf;
    logic               n_dir;
    logic [CAP_W-1:0]   n_rc;
    logic [TOTAL_W-1:0] n_deliv;
    t_out_item          n_result;

    t_floor                w_rid_rd_addr;
    t_floor                w_rid_addr;
    t_count                w_up_val;
    t_count                w_dn_val;
    t_count                w_rid_val;
    logic [MAX_FLOORS-1:0] w_up_nz;
    logic [MAX_FLOORS-1:0] w_dn_nz;
    logic [MAX_FLOORS-1:0] w_rid_nz;
    t_cnt_wr               w_up_wr;
    t_cnt_wr               w_dn_wr;
    t_cnt_wr               w_rid_wr;

    logic [NF_W-1:0]       w_nf;
    t_floor                w_top;
    logic [MAX_FLOORS-1:0] w_busy_vec;
    logic [MAX_FLOORS-1:0] w_above;
    logic [MAX_FLOORS-1:0] w_below;
    logic                  w_pick_up;
    logic                  w_fl_ok;
    logic                  w_tg_ok;
    logic                  w_call_up;
    logic                  w_ok;
    logic                  w_exit;
    logic                  w_up_here;
    logic                  w_dn_here;
    logic                  w_here;

    assign busy = 1'b0;

    // counter RAMs are addressed straight from the input so read data lines up
    // with the registered event
    assign w_rid_rd_addr = (i_item.cmd == CMD_BOARD) ? i_item.target : i_item.floor;
    assign w_rid_addr    = (r_item.cmd == CMD_BOARD) ? r_item.target : r_item.floor;

    elc_cnt_store u_up_calls (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (i_item.floor),
        .o_rd_val  (w_up_val),
        .i_wr      (w_up_wr),
        .o_nz      (w_up_nz)
    );

    elc_cnt_store u_down_calls (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (i_item.floor),
        .o_rd_val  (w_dn_val),
        .i_wr      (w_dn_wr),
        .o_nz      (w_dn_nz)
    );

    elc_cnt_store u_riders (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_rid_rd_addr),
        .o_rd_val  (w_rid_val),
        .i_wr      (w_rid_wr),
        .o_nz      (w_rid_nz)
    );

    always_comb begin
        if (r_floors < NF_W'(2)) begin
            w_nf = NF_W'(2);
        end else if (r_floors > NF_W'(MAX_FLOORS)) begin
            w_nf = NF_W'(MAX_FLOORS);
        end else begin
            w_nf = r_floors;
        end
    end

    assign w_top   = FLOOR_W'(w_nf - NF_W'(1));
    assign w_fl_ok = NF_W'(r_item.floor) < w_nf;
    assign w_tg_ok = NF_W'(r_item.target) < w_nf;
    assign w_call_up = r_item.floor < r_item.target;

    assign w_busy_vec = w_up_nz | w_dn_nz | w_rid_nz;

    always_comb begin
        for (int i = 0; i < MAX_FLOORS; i++) begin
            w_above[i] = (FLOOR_W'(i) > r_cf) && (FLOOR_W'(i) <= w_top);
            w_below[i] = FLOOR_W'(i) < r_cf;
        end
    end

    always_comb begin
        if (r_cf == '0) begin
            w_pick_up = 1'b1;
        end else if (r_cf >= w_top) begin
            w_pick_up = 1'b0;
        end else if (r_dir) begin
            w_pick_up = |(w_busy_vec & w_above);
        end else begin
            w_pick_up = !(|(w_busy_vec & w_below));
        end
    end

    always_comb begin
        n_cf     = r_cf;
        n_dir    = r_dir;
        n_rc     = r_rc;
        n_deliv  = r_deliv;
        w_ok     = 1'b0;
        w_up_wr  = '{en: 1'b0, addr: r_item.floor, val: w_up_val};
        w_dn_wr  = '{en: 1'b0, addr: r_item.floor, val: w_dn_val};
        w_rid_wr = '{en: 1'b0, addr: w_rid_addr, val: w_rid_val};
        if (r_vld) begin
            case (r_item.cmd)
                CMD_PRESS: begin
                    if (w_fl_ok && w_tg_ok) begin
                        w_ok = 1'b1;
                        if (w_call_up) begin
                            w_up_wr.en = 1'b1;
                            if (w_up_val != CNT_MAX) begin
                                w_up_wr.val = w_up_val + 1'b1;
                            end
                        end else begin
                            w_dn_wr.en = 1'b1;
                            if (w_dn_val != CNT_MAX) begin
                                w_dn_wr.val = w_dn_val + 1'b1;
                            end
                        end
                    end
                end
                CMD_BOARD: begin
                    if (w_fl_ok && w_tg_ok && (r_item.floor == r_cf) && (r_rc < r_cap)
                        && (w_rid_val != CNT_MAX)) begin
                        w_ok = 1'b1;
                        if (w_call_up) begin
                            w_up_wr.en = 1'b1;
                            if (w_up_val != '0) begin
                                w_up_wr.val = w_up_val - 1'b1;
                            end
                        end else begin
                            w_dn_wr.en = 1'b1;
                            if (w_dn_val != '0) begin
                                w_dn_wr.val = w_dn_val - 1'b1;
                            end
                        end
                        w_rid_wr.en  = 1'b1;
                        w_rid_wr.val = w_rid_val + 1'b1;
                        n_rc         = r_rc + 1'b1;
                    end
                end
                CMD_ALIGHT: begin
                    if (w_fl_ok && (r_item.floor == r_cf) && (w_rid_val != '0)
                        && (r_rc != '0)) begin
                        w_ok         = 1'b1;
                        w_rid_wr.en  = 1'b1;
                        w_rid_wr.val = w_rid_val - 1'b1;
                        n_rc         = r_rc - 1'b1;
                        n_deliv      = r_deliv + 1'b1;
                    end
                end
                CMD_TICK: begin
                    w_ok  = 1'b1;
                    n_dir = w_pick_up;
                    n_cf  = w_pick_up ? (r_cf + 1'b1) : (r_cf - 1'b1);
                end
                default: begin
                    w_ok = 1'b0;
                end
            endcase
        end
    end

    // flags at the car's floor as they stand after this event's writes
    always_comb begin
        if (w_rid_wr.en && (w_rid_wr.addr == n_cf)) begin
            w_exit = (w_rid_wr.val != '0);
        end else begin
            w_exit = w_rid_nz[n_cf];
        end
        if (w_up_wr.en && (w_up_wr.addr == n_cf)) begin
            w_up_here = (w_up_wr.val != '0);
        end else begin
            w_up_here = w_up_nz[n_cf];
        end
        if (w_dn_wr.en && (w_dn_wr.addr == n_cf)) begin
            w_dn_here = (w_dn_wr.val != '0);
        end else begin
            w_dn_here = w_dn_nz[n_cf];
        end
        w_here = n_dir ? w_up_here : w_dn_here;
        // at either end floor a call in any direction counts
        if ((n_cf == '0) || (n_cf == w_top)) begin
            w_here = w_up_here || w_dn_here;
        end
    end

    always_comb begin
        n_result.accepted          = w_ok;
        n_result.car_floor         = n_cf;
        n_result.going_up          = n_dir;
        n_result.riders            = n_rc;
        n_result.exits_waiting     = w_exit;
        n_result.entries_waiting   = w_here && (n_rc < r_cap);
        n_result.transported_total = n_deliv;
    end

    always_ff @(posedge i_clk) begin
        r_item   <= i_item;
        r_result <= n_result;
        if (!i_rst_n) begin
            r_vld    <= 1'b0;
            r_strobe <= 1'b0;
            r_cf     <= '0;
            r_dir    <= 1'b1;
            r_rc     <= '0;
            r_deliv  <= '0;
        end else begin
            r_vld    <= start && !busy;
            r_strobe <= r_vld;
            if (r_vld) begin
                r_cf    <= n_cf;
                r_dir   <= n_dir;
                r_rc    <= n_rc;
                r_deliv <= n_deliv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floors <= FLOORS_RESET;
            r_cap    <= CAP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FLOORS:   r_floors <= i_cfg_data[NF_W-1:0];
                CFG_CAPACITY: r_cap    <= i_cfg_data[CAP_W-1:0];
                default:      r_cap    <= r_cap;
            endcase
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_tick_moves_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && (r_item.cmd == CMD_TICK)) |=>
            ((r_cf == $past(r_cf) + 1'b1) || (r_cf == $past(r_cf) - 1'b1)))
        else $error("tick did not move the car by one floor");

    a_riders_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld |=> (r_rc == $past(r_rc)))
        else $error("rider count changed without an event");

    a_deliv_on_alight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (r_deliv != $past(r_deliv))) |->
            $past(r_vld && (r_item.cmd == CMD_ALIGHT)))
        else $error("delivered total changed outside an alight");

endmodule
